### rtl/psls_pkg.sv
package psls_pkg;

    localparam int NUM_SENSORS = 128;
    localparam int COUNT_BITS  = 14;

    localparam int ID_W     = 7;
    localparam int TIME_W   = 32;
    localparam int LUX_W    = 22;
    localparam int OUT_CNT_W = 14;
    localparam int ADDR_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SUM_W    = LUX_W + COUNT_BITS;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [OUT_CNT_W-1:0]  OUTLIER_MAX = {OUT_CNT_W{1'b1}};

    localparam logic [LUX_W-1:0] LOWER_RESET = LUX_W'(100);
    localparam logic [LUX_W-1:0] UPPER_RESET = LUX_W'(3500000);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   sensor_id;
        logic [TIME_W-1:0] sample_time;
        logic [LUX_W-1:0]  lux_hundredths;
    } sample_t;

    typedef struct packed {
        logic                 is_outlier;
        logic [OUT_CNT_W-1:0] sample_count;
        logic [LUX_W-1:0]     min_lux;
        logic [TIME_W-1:0]    min_time;
        logic [LUX_W-1:0]     max_lux;
        logic [TIME_W-1:0]    max_time;
        logic [LUX_W-1:0]     mean_lux;
        logic [TIME_W-1:0]    span_seconds;
        logic [OUT_CNT_W-1:0] outlier_total;
    } result_t;

    // one sensor entry as held in the statistics memory
    typedef struct packed {
        logic [SUM_W-1:0]      sum;
        logic [COUNT_BITS-1:0] count;
        logic [LUX_W-1:0]      min_lux;
        logic [TIME_W-1:0]     min_time;
        logic [LUX_W-1:0]      max_lux;
        logic [TIME_W-1:0]     max_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/psls_ram.sv
module psls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/per_sensor_lux_statistics_top.sv
// after the start transfer a sample passes S_UPDATE and then S_DIV, and result_valid
// is registered from the last S_DIV step; start is taken again in the strobe cycle
// no start is taken while busy; the mean divider gives one quotient bit per cycle
// each result is shown for one cycle with result_valid; the receiver cannot stall
// rst_n clears the valid bits of the sensor table, the global times and the outlier
// total, and loads the limit registers with their defaults; no clearing pass is needed
module per_sensor_lux_statistics_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  psls_pkg::sample_t                    sample,
    output logic                                 result_valid,
    output psls_pkg::result_t                    result,
    input  logic                                 cfg_write,
    input  logic [psls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psls_pkg::LUX_W-1:0]           cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [psls_pkg::LUX_W-1:0]       lower_reg, lower_next;
    logic [psls_pkg::LUX_W-1:0]       upper_reg, upper_next;
    logic [psls_pkg::NUM_SENSORS-1:0] valid_reg, valid_next;
    logic [psls_pkg::TIME_W-1:0]      earliest_reg, earliest_next;
    logic [psls_pkg::TIME_W-1:0]      latest_reg, latest_next;
    logic                             seen_reg, seen_next;
    logic [psls_pkg::OUT_CNT_W-1:0]   outl_cnt_reg, outl_cnt_next;
    logic [psls_pkg::DIV_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                             strobe_reg, strobe_next;

    logic [psls_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [psls_pkg::TIME_W-1:0]      time_reg, time_next;
    logic [psls_pkg::LUX_W-1:0]       lux_reg, lux_next;
    logic                             outlier_reg, outlier_next;
    logic                             has_entry_reg, has_entry_next;
    psls_pkg::entry_t                 entry_reg, entry_next;
    logic [psls_pkg::SUM_W-1:0]       quot_reg, quot_next;
    logic [psls_pkg::COUNT_BITS-1:0]  rem_reg, rem_next;
    psls_pkg::result_t                result_reg, result_next;

    logic                             ram_we;
    logic [psls_pkg::ADDR_W-1:0]      ram_addr;
    psls_pkg::entry_t                 ram_wdata;
    logic [psls_pkg::ENTRY_W-1:0]     ram_rdata;

    psls_ram #(
        .WIDTH (psls_pkg::ENTRY_W),
        .DEPTH (psls_pkg::NUM_SENSORS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        psls_pkg::entry_t                old_entry;
        psls_pkg::entry_t                new_entry;
        logic                            id_ok;
        logic [psls_pkg::COUNT_BITS:0]   trial;
        logic                            qbit;

        state_next     = state_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        valid_next     = valid_reg;
        earliest_next  = earliest_reg;
        latest_next    = latest_reg;
        seen_next      = seen_reg;
        outl_cnt_next  = outl_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        strobe_next    = 1'b0;
        addr_next      = addr_reg;
        time_next      = time_reg;
        lux_next       = lux_reg;
        outlier_next   = outlier_reg;
        has_entry_next = has_entry_reg;
        entry_next     = entry_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = entry_reg;
        old_entry      = psls_pkg::entry_t'(ram_rdata);
        new_entry      = old_entry;
        trial          = '0;
        qbit           = 1'b0;

        id_ok = 32'(sample.sensor_id) < 32'(psls_pkg::NUM_SENSORS);

        if (cfg_write)
        begin
            case (cfg_index)
                psls_pkg::REG_LOWER_LIMIT: lower_next = cfg_data;
                psls_pkg::REG_UPPER_LIMIT: upper_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_addr = psls_pkg::ADDR_W'(sample.sensor_id);
                if (start)
                begin
                    addr_next    = psls_pkg::ADDR_W'(sample.sensor_id);
                    time_next    = sample.sample_time;
                    lux_next     = sample.lux_hundredths;
                    outlier_next = !id_ok || (sample.lux_hundredths < lower_reg)
                                   || (sample.lux_hundredths > upper_reg);
                    has_entry_next = id_ok;
                    state_next   = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (!valid_reg[addr_reg])
                begin
                    old_entry = '0;
                end
                new_entry = old_entry;
                if (outlier_reg)
                begin
                    if (outl_cnt_reg != psls_pkg::OUTLIER_MAX)
                    begin
                        outl_cnt_next = outl_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (old_entry.count == '0)
                    begin
                        new_entry.sum      = psls_pkg::SUM_W'(lux_reg);
                        new_entry.count    = psls_pkg::COUNT_BITS'(1);
                        new_entry.min_lux  = lux_reg;
                        new_entry.min_time = time_reg;
                        new_entry.max_lux  = lux_reg;
                        new_entry.max_time = time_reg;
                    end
                    else
                    begin
                        if (old_entry.count != psls_pkg::COUNT_MAX)
                        begin
                            new_entry.sum   = old_entry.sum + psls_pkg::SUM_W'(lux_reg);
                            new_entry.count = old_entry.count + 1'b1;
                        end
                        if (lux_reg < old_entry.min_lux)
                        begin
                            new_entry.min_lux  = lux_reg;
                            new_entry.min_time = time_reg;
                        end
                        if (lux_reg > old_entry.max_lux)
                        begin
                            new_entry.max_lux  = lux_reg;
                            new_entry.max_time = time_reg;
                        end
                    end
                    ram_we               = 1'b1;
                    ram_wdata            = new_entry;
                    valid_next[addr_reg] = 1'b1;
                    if (!seen_reg)
                    begin
                        earliest_next = time_reg;
                        latest_next   = time_reg;
                        seen_next     = 1'b1;
                    end
                    else
                    begin
                        if (time_reg < earliest_reg)
                        begin
                            earliest_next = time_reg;
                        end
                        if (time_reg > latest_reg)
                        begin
                            latest_next = time_reg;
                        end
                    end
                end
                has_entry_next = has_entry_reg && (new_entry.count != '0);
                entry_next     = new_entry;
                quot_next      = new_entry.sum;
                rem_next       = '0;
                bit_cnt_next   = psls_pkg::DIV_CNT_W'(psls_pkg::SUM_W);
                state_next     = S_DIV;
            end

            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                trial = {rem_reg, quot_reg[psls_pkg::SUM_W-1]};
                if (trial >= {1'b0, entry_reg.count})
                begin
                    qbit     = 1'b1;
                    rem_next = psls_pkg::COUNT_BITS'(trial - {1'b0, entry_reg.count});
                end
                else
                begin
                    rem_next = psls_pkg::COUNT_BITS'(trial);
                end
                quot_next    = {quot_reg[psls_pkg::SUM_W-2:0], qbit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == psls_pkg::DIV_CNT_W'(1))
                begin
                    result_next = '0;
                    result_next.is_outlier = outlier_reg;
                    if (has_entry_reg)
                    begin
                        result_next.sample_count = psls_pkg::OUT_CNT_W'(entry_reg.count);
                        result_next.min_lux      = entry_reg.min_lux;
                        result_next.min_time     = entry_reg.min_time;
                        result_next.max_lux      = entry_reg.max_lux;
                        result_next.max_time     = entry_reg.max_time;
                        result_next.mean_lux     = quot_next[psls_pkg::LUX_W-1:0];
                    end
                    if (seen_reg)
                    begin
                        result_next.span_seconds = latest_reg - earliest_reg;
                    end
                    result_next.outlier_total = outl_cnt_reg;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lower_reg    <= psls_pkg::LOWER_RESET;
            upper_reg    <= psls_pkg::UPPER_RESET;
            valid_reg    <= '0;
            earliest_reg <= '0;
            latest_reg   <= '0;
            seen_reg     <= 1'b0;
            outl_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lower_reg    <= lower_next;
            upper_reg    <= upper_next;
            valid_reg    <= valid_next;
            earliest_reg <= earliest_next;
            latest_reg   <= latest_next;
            seen_reg     <= seen_next;
            outl_cnt_reg <= outl_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        time_reg      <= time_next;
        lux_reg       <= lux_next;
        outlier_reg   <= outlier_next;
        has_entry_reg <= has_entry_next;
        entry_reg     <= entry_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        result_reg    <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = strobe_reg;
    assign result       = result_reg;

endmodule

### tb/sv/tb_per_sensor_lux_statistics_top.sv
module tb_per_sensor_lux_statistics_top;

    timeunit 1ns;
    timeprecision 1ps;

    import psls_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [LUX_W-1:0] LUX_ALL_ONES = {LUX_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_ALL_ONES = {TIME_W{1'b1}};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sample_t sample;
    logic result_valid;
    result_t result;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LUX_W-1:0] cfg_data;

    // expected statistics, oldest first
    result_t pending_stats[$];
    result_t want;
    int mismatch_count;
    int cycle_count;

    // shadow copy of the sensor table and globals
    logic [SUM_W-1:0] sum_tbl [NUM_SENSORS];
    logic [COUNT_BITS-1:0] cnt_tbl [NUM_SENSORS];
    logic [LUX_W-1:0] min_tbl [NUM_SENSORS];
    logic [TIME_W-1:0] min_t_tbl [NUM_SENSORS];
    logic [LUX_W-1:0] max_tbl [NUM_SENSORS];
    logic [TIME_W-1:0] max_t_tbl [NUM_SENSORS];
    logic [TIME_W-1:0] earliest_seen;
    logic [TIME_W-1:0] latest_seen;
    bit any_valid;
    logic [OUT_CNT_W-1:0] outlier_seen;
    logic [LUX_W-1:0] lower_lim;
    logic [LUX_W-1:0] upper_lim;
    logic [TIME_W-1:0] time_base;

    per_sensor_lux_statistics_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic result_t predict_stats(input sample_t s);
        result_t r;
        int id;
        bit id_ok;
        bit outl;
        logic [LUX_W-1:0] lux;
        logic [TIME_W-1:0] t;
        r = '0;
        id = int'(s.sensor_id);
        lux = s.lux_hundredths;
        t = s.sample_time;
        id_ok = id < NUM_SENSORS;
        outl = !id_ok || lux < lower_lim || lux > upper_lim;
        if (outl)
        begin
            if (outlier_seen != OUTLIER_MAX)
                outlier_seen = outlier_seen + 1'b1;
        end
        else
        begin
            if (cnt_tbl[id] == '0)
            begin
                sum_tbl[id] = SUM_W'(lux);
                cnt_tbl[id] = COUNT_BITS'(1);
                min_tbl[id] = lux;
                min_t_tbl[id] = t;
                max_tbl[id] = lux;
                max_t_tbl[id] = t;
            end
            else
            begin
                if (cnt_tbl[id] != COUNT_MAX)
                begin
                    sum_tbl[id] = sum_tbl[id] + SUM_W'(lux);
                    cnt_tbl[id] = cnt_tbl[id] + 1'b1;
                end
                if (lux < min_tbl[id])
                begin
                    min_tbl[id] = lux;
                    min_t_tbl[id] = t;
                end
                if (lux > max_tbl[id])
                begin
                    max_tbl[id] = lux;
                    max_t_tbl[id] = t;
                end
            end
            if (!any_valid)
            begin
                earliest_seen = t;
                latest_seen = t;
                any_valid = 1'b1;
            end
            else
            begin
                if (t < earliest_seen)
                    earliest_seen = t;
                if (t > latest_seen)
                    latest_seen = t;
            end
        end
        r.is_outlier = outl;
        if (id_ok && cnt_tbl[id] != '0)
        begin
            r.sample_count = OUT_CNT_W'(cnt_tbl[id]);
            r.min_lux = min_tbl[id];
            r.min_time = min_t_tbl[id];
            r.max_lux = max_tbl[id];
            r.max_time = max_t_tbl[id];
            r.mean_lux = LUX_W'(sum_tbl[id] / SUM_W'(cnt_tbl[id]));
        end
        r.span_seconds = any_valid ? latest_seen - earliest_seen : '0;
        r.outlier_total = outlier_seen;
        return r;
    endfunction

    function automatic sample_t make_sample(input int id, input logic [TIME_W-1:0] t,
                                            input logic [LUX_W-1:0] lux);
        sample_t s;
        s.sensor_id = ID_W'(id);
        s.sample_time = t;
        s.lux_hundredths = lux;
        return s;
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int pick;
        pick = $urandom_range(0, 9);
        s.sensor_id = (pick < 7) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.sample_time = '0;
        else if (pick == 1)
            s.sample_time = TIME_ALL_ONES;
        else if (pick < 6)
            s.sample_time = time_base + TIME_W'($urandom_range(0, 1000));
        else
            s.sample_time = $urandom;
        pick = $urandom_range(0, 19);
        if (lower_lim > upper_lim || pick < 2)
            s.lux_hundredths = LUX_W'($urandom);
        else if (pick == 2)
            s.lux_hundredths = lower_lim;
        else if (pick == 3)
            s.lux_hundredths = upper_lim;
        else
            s.lux_hundredths = LUX_W'($urandom_range(upper_lim, lower_lim));
        return s;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_val,
                               input logic [TIME_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("is_outlier", TIME_W'(want.is_outlier),
                            TIME_W'(result.is_outlier));
                check_field("sample_count", TIME_W'(want.sample_count),
                            TIME_W'(result.sample_count));
                check_field("min_lux", TIME_W'(want.min_lux), TIME_W'(result.min_lux));
                check_field("min_time", want.min_time, result.min_time);
                check_field("max_lux", TIME_W'(want.max_lux), TIME_W'(result.max_lux));
                check_field("max_time", want.max_time, result.max_time);
                check_field("mean_lux", TIME_W'(want.mean_lux), TIME_W'(result.mean_lux));
                check_field("span_seconds", want.span_seconds, result.span_seconds);
                check_field("outlier_total", TIME_W'(want.outlier_total),
                            TIME_W'(result.outlier_total));
            end
        end
    end

    // start stays high after a transfer so back-to-back samples need no toggle
    task automatic send_sample(input sample_t s);
        start <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        pending_stats.push_back(predict_stats(s));
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(input logic [LUX_W-1:0] lo, input logic [LUX_W-1:0] hi);
        cfg_write <= 1'b1;
        cfg_index <= REG_LOWER_LIMIT;
        cfg_data <= lo;
        @(posedge clk);
        lower_lim = lo;
        cfg_index <= REG_UPPER_LIMIT;
        cfg_data <= hi;
        @(posedge clk);
        upper_lim = hi;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(make_sample(0, 100, 99));
        send_sample(make_sample(0, 1000, 100));
        send_sample(make_sample(127, TIME_ALL_ONES, 3500000));
        send_sample(make_sample(127, 5, 3500001));
        send_sample(make_sample(1, 0, 0));
        send_sample(make_sample(1, 0, LUX_ALL_ONES));
        send_sample(make_sample(1, 0, 150));
    endtask

    task automatic test_ties();
        send_sample(make_sample(3, 10, 5000));
        send_sample(make_sample(3, 5, 5000));
        send_sample(make_sample(3, 20, 7000));
        send_sample(make_sample(3, 1, 7000));
        send_sample(make_sample(3, 30, 200));
        send_sample(make_sample(3, 2, 200));
    endtask

    task automatic test_limit_settings();
        wait_all_results();
        set_limits('0, LUX_ALL_ONES);
        send_sample(make_sample(10, 400, 0));
        send_sample(make_sample(10, 401, LUX_ALL_ONES));
        wait_all_results();
        set_limits(3000, 2000);
        send_sample(make_sample(10, 402, 2500));
        send_sample(make_sample(10, 403, 3000));
        send_sample(make_sample(10, 404, 2000));
        wait_all_results();
        set_limits(777, 777);
        send_sample(make_sample(10, 405, 777));
        send_sample(make_sample(10, 406, 776));
        send_sample(make_sample(10, 407, 778));
    endtask

    task automatic test_full_range();
        wait_all_results();
        set_limits('0, LUX_ALL_ONES);
        send_sample(make_sample(9, 50, 1000));
        send_sample(make_sample(9, 77, 0));
        send_sample(make_sample(9, 78, LUX_ALL_ONES));
        send_sample(make_sample(9, 79, LUX_ALL_ONES));
        send_sample(make_sample(9, TIME_ALL_ONES, LUX_ALL_ONES));
        send_sample(make_sample(9, 0, 0));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int burst_left;
        logic [LUX_W-1:0] lo;
        logic [LUX_W-1:0] hi;
        burst_left = $urandom_range(1, 20);
        for (phase = 0; phase < 5; phase++)
        begin
            wait_all_results();
            lo = LUX_W'($urandom);
            hi = LUX_W'($urandom);
            case (phase)
                0: set_limits(LOWER_RESET, UPPER_RESET);
                1: set_limits((lo < hi) ? lo : hi, (lo < hi) ? hi : lo);
                2: set_limits('0, LUX_ALL_ONES);
                3: set_limits(lo >> 1, (lo >> 1) + LUX_W'($urandom_range(0, 50)));
                default: set_limits(lo, hi);
            endcase
            time_base = $urandom;
            for (n = 0; n < 220; n++)
            begin
                send_sample(rand_sample());
                burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        burst_left = $urandom_range(30, 60);
                    else
                        burst_left = $urandom_range(1, 20);
                    hold_off($urandom_range(1, 80));
                end
                if (phase == 2 && n == 110)
                    wait_all_results();
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
        any_valid = 1'b0;
        outlier_seen = '0;
        earliest_seen = '0;
        latest_seen = '0;
        lower_lim = LOWER_RESET;
        upper_lim = UPPER_RESET;
        time_base = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
            cnt_tbl[i] = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        sample <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_LOWER_LIMIT;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_ties();
        test_limit_settings();
        test_full_range();
        test_random_traffic();
        wait_all_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### per_sensor_lux_statistics_top.f
rtl/psls_pkg.sv
rtl/psls_ram.sv
rtl/per_sensor_lux_statistics_top.sv
tb/sv/tb_per_sensor_lux_statistics_top.sv
